// ===== rtl/dsw_pkg.sv =====
`default_nettype none
package dsw_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHN_W    = 3;
    localparam int WORD_W   = 32;

    typedef logic [CH_W-1:0]   t_idx;
    typedef logic [CHN_W-1:0]  t_chn;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic {
        OP_TRIGGER = 1'b0,
        OP_INSPECT = 1'b1
    } t_op;

    localparam t_idx IDX_LAST = CH_W'(CHANNELS - 1);

    // Handles and progress count, one row per channel
    typedef struct packed {
        t_word src;
        t_word dst;
        t_word cnt;
    } t_row;

    typedef struct packed {
        logic en;
        t_idx idx;
        t_row row;
    } t_row_wr;

    typedef struct packed {
        logic  en;
        t_idx  idx;
        t_word cnt;
    } t_chk_wr;

    function automatic t_idx f_chn2idx(input t_chn chn);
        logic [CH_W+CHN_W-1:0] wide;
        wide = {{CH_W{1'b0}}, chn};
        return wide[CH_W-1:0];
    endfunction

    function automatic t_chn f_idx2chn(input t_idx idx);
        logic [CH_W+CHN_W-1:0] wide;
        wide = {{CHN_W{1'b0}}, idx};
        return wide[CHN_W-1:0];
    endfunction

    function automatic logic f_chn_ok(input t_chn chn);
        logic [WORD_W-1:0] wide;
        wide = {{(WORD_W-CHN_W){1'b0}}, chn};
        return wide < WORD_W'(CHANNELS);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dsw_if.sv =====
`default_nettype none
interface dsw_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [2:0]  channel;
    logic [31:0] msg_source;
    logic [31:0] msg_dest;

    modport source (output valid, opcode, channel, msg_source, msg_dest, input ready);
    modport sink   (input valid, opcode, channel, msg_source, msg_dest, output ready);
endinterface

interface dsw_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  report_channel;
    logic [31:0] report_source;
    logic [31:0] report_dest;
    logic [31:0] report_count;
    logic        stuck;
    logic        last;

    modport source (output valid, report_channel, report_source, report_dest,
                    report_count, stuck, last, input ready);
    modport sink   (input valid, report_channel, report_source, report_dest,
                    report_count, stuck, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/dsw_store.sv =====
`default_nettype none
module dsw_store (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dsw_pkg::t_idx   i_row_raddr,
    output      dsw_pkg::t_row   o_row_rdata,
    input  wire dsw_pkg::t_row_wr i_row_wr,
    input  wire dsw_pkg::t_idx   i_chk_raddr,
    output      dsw_pkg::t_word  o_chk_rdata,
    input  wire dsw_pkg::t_chk_wr i_chk_wr
);
    import dsw_pkg::*;

    t_row  r_mem_row [CHANNELS];
    t_word r_mem_chk [CHANNELS];

    // Entry-written flags: an unwritten entry reads as zero
    logic [CHANNELS-1:0] r_vld_row;
    logic [CHANNELS-1:0] r_vld_chk;

    t_row  r_row_q;
    t_word r_chk_q;
    logic  r_row_qv;
    logic  r_chk_qv;

    always_ff @(posedge i_clk) begin
        if (i_row_wr.en) begin
            r_mem_row[i_row_wr.idx] <= i_row_wr.row;
        end
        if (i_chk_wr.en) begin
            r_mem_chk[i_chk_wr.idx] <= i_chk_wr.cnt;
        end
        r_row_q <= r_mem_row[i_row_raddr];
        r_chk_q <= r_mem_chk[i_chk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_row <= '0;
            r_vld_chk <= '0;
            r_row_qv  <= 1'b0;
            r_chk_qv  <= 1'b0;
        end else begin
            if (i_row_wr.en) begin
                r_vld_row[i_row_wr.idx] <= 1'b1;
            end
            if (i_chk_wr.en) begin
                r_vld_chk[i_chk_wr.idx] <= 1'b1;
            end
            r_row_qv <= r_vld_row[i_row_raddr];
            r_chk_qv <= r_vld_chk[i_chk_raddr];
        end
    end

    assign o_row_rdata = r_row_qv ? r_row_q : '0;
    assign o_chk_rdata = r_chk_qv ? r_chk_q : '0;

endmodule
`default_nettype wire

// ===== rtl/dispatch_stall_watchdog.sv =====
`default_nettype none
// Per-channel stall watchdog for message dispatch workers. A trigger beat
// (opcode 0) records the source and destination handles of the message a
// channel is now handling and bumps that channel's 32-bit progress count,
// which wraps; triggers naming a channel at or above CHANNELS are dropped.
// Triggers are taken one per cycle while idle, with no bubbles: the count
// is a read-modify-write on a RAM with a registered read, and back-to-back
// triggers to the same channel are covered by forwarding the count just
// written. An inspect beat (opcode 1) walks channels 0..CHANNELS-1 and emits
// one report beat each; a channel whose count is unchanged since the previous
// inspect and whose destination is nonzero is flagged stuck, otherwise its
// checked count catches up. Each channel of the walk passes a RAM read
// state, then an evaluate-and-write-back state; ready stays low from an inspect
// until the last report is loaded, later if the sink stalls. The last report
// may still wait in the output register while the next beat is accepted.
// All state reads as zero after reset; there is no clearing pass.
module dispatch_stall_watchdog (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dsw_in_if.sink     i_in,
    dsw_out_if.source  o_out
);
    import dsw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EVAL
    } t_state;

    t_state r_state, n_state;
    t_idx   r_idx, n_idx;

    // trigger write-back stage
    logic  r_t_vld, n_t_vld;
    t_idx  r_t_idx;
    t_word r_t_src;
    t_word r_t_dst;

    // last count written, for same-channel trigger back to back
    logic  r_f_vld;
    t_idx  r_f_idx;
    t_word r_f_cnt;

    // report register
    logic  r_o_vld, n_o_vld;
    logic  o_load;
    t_chn  r_o_chn;
    t_word r_o_src;
    t_word r_o_dst;
    t_word r_o_cnt;
    logic  r_o_stuck;
    logic  r_o_last;

    t_idx    row_raddr;
    t_row    row_rdata;
    t_word   chk_rdata;
    t_row_wr row_wr;
    t_chk_wr chk_wr;

    logic  in_acc;
    t_word base_cnt;
    logic  is_last;
    logic  stuck;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // In idle the RAM reads on the incoming channel, during a walk on r_idx
    assign row_raddr = (r_state == S_IDLE) ? f_chn2idx(i_in.channel) : r_idx;

    dsw_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_raddr (row_raddr),
        .o_row_rdata (row_rdata),
        .i_row_wr    (row_wr),
        .i_chk_raddr (r_idx),
        .o_chk_rdata (chk_rdata),
        .i_chk_wr    (chk_wr)
    );

    // Trigger write-back: count + 1, handles overwritten
    always_comb begin
        base_cnt = (r_f_vld && (r_f_idx == r_t_idx)) ? r_f_cnt : row_rdata.cnt;
        row_wr.en      = r_t_vld;
        row_wr.idx     = r_t_idx;
        row_wr.row.src = r_t_src;
        row_wr.row.dst = r_t_dst;
        row_wr.row.cnt = base_cnt + WORD_W'(1);
    end

    // Walk evaluation
    always_comb begin
        is_last    = (r_idx == IDX_LAST);
        stuck      = (row_rdata.cnt == chk_rdata) && (row_rdata.dst != '0);
        o_load     = (r_state == S_EVAL) && (!r_o_vld || o_out.ready);
        chk_wr.en  = o_load && (row_rdata.cnt != chk_rdata);
        chk_wr.idx = r_idx;
        chk_wr.cnt = row_rdata.cnt;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_t_vld = in_acc && (i_in.opcode == OP_TRIGGER) && f_chn_ok(i_in.channel);
        n_o_vld = r_o_vld && !o_out.ready;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.opcode == OP_INSPECT)) begin
                    n_state = S_RD;
                    n_idx   = '0;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (o_load) begin
                    n_o_vld = 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD;
                        n_idx   = r_idx + CH_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_t_idx <= f_chn2idx(i_in.channel);
        r_t_src <= i_in.msg_source;
        r_t_dst <= i_in.msg_dest;
        r_f_idx <= r_t_idx;
        r_f_cnt <= row_wr.row.cnt;
        r_idx   <= n_idx;
        if (o_load) begin
            r_o_chn   <= f_idx2chn(r_idx);
            r_o_src   <= row_rdata.src;
            r_o_dst   <= row_rdata.dst;
            r_o_cnt   <= row_rdata.cnt;
            r_o_stuck <= stuck;
            r_o_last  <= is_last;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t_vld <= n_t_vld;
            r_f_vld <= r_t_vld;
            r_o_vld <= n_o_vld;
        end
    end

    assign o_out.valid          = r_o_vld;
    assign o_out.report_channel = r_o_chn;
    assign o_out.report_source  = r_o_src;
    assign o_out.report_dest    = r_o_dst;
    assign o_out.report_count   = r_o_cnt;
    assign o_out.stuck          = r_o_stuck;
    assign o_out.last           = r_o_last;

endmodule
`default_nettype wire

// ===== rtl/dsw_checker.sv =====
`default_nettype none
module dsw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_opcode,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_out_channel,
    input wire logic [31:0] i_out_dest,
    input wire logic        i_out_stuck,
    input wire logic        i_out_last
);
    import dsw_pkg::*;

    // A stalled report holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_channel))
        else $error("report beat changed while stalled");

    // Mid-walk reports mean the walk still owns the block
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready during channel walk");

    a_last_chn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_channel == f_idx2chn(IDX_LAST))
        else $error("last flag on wrong channel");

    a_stuck_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stuck |-> i_out_dest != '0)
        else $error("idle channel flagged stuck");

    a_trig_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == OP_TRIGGER) && !i_out_valid
        |=> !i_out_valid)
        else $error("report after trigger");

endmodule

bind dispatch_stall_watchdog dsw_checker u_dsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_opcode   (i_in.opcode),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_channel (o_out.report_channel),
    .i_out_dest    (o_out.report_dest),
    .i_out_stuck   (o_out.stuck),
    .i_out_last    (o_out.last)
);
`default_nettype wire

// ===== sim/dsw_watchdog_monitor.sv =====
`timescale 1ns / 1ps
// Watches both channels of the stall watchdog, keeps its own copy of the
// per-channel store and compares each report beat with the oldest one due.
module dsw_watchdog_monitor (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsw_in_if         in_mon,
    dsw_out_if        out_mon,
    output int        o_errors,
    output int        o_pending
);
    import dsw_pkg::*;

    typedef struct {
        t_chn  chn;
        t_word src;
        t_word dst;
        t_word cnt;
        logic  stuck;
        logic  last;
    } t_report;

    t_word   progress [CHANNELS];
    t_word   checked  [CHANNELS];
    t_word   held_src [CHANNELS];
    t_word   held_dst [CHANNELS];
    t_report reports_due[$];
    int      errors;

    task automatic log_mismatch(input string field, input t_word got, input t_word want);
        $display("[%0t] report mismatch on %s: got %h, want %h", $realtime, field, got, want);
        errors++;
    endtask

    // Trigger updates one channel; inspect sweeps all of them and queues one
    // report per channel, snapshotting before the checked count catches up.
    task automatic track_command(input logic opc, input t_chn chn, input t_word src,
                                 input t_word dst);
        t_report r;
        int      ch;
        ch = int'(chn);
        if (t_op'(opc) == OP_TRIGGER) begin
            if (ch < CHANNELS) begin
                held_src[ch] = src;
                held_dst[ch] = dst;
                progress[ch] = progress[ch] + 1;
            end
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                r.chn   = t_chn'(i);
                r.src   = held_src[i];
                r.dst   = held_dst[i];
                r.cnt   = progress[i];
                r.stuck = (progress[i] == checked[i]) && (held_dst[i] != '0);
                r.last  = (i == CHANNELS - 1);
                checked[i] = progress[i];
                reports_due = {reports_due, r};
            end
        end
    endtask

    task automatic check_report();
        t_report want;
        if (reports_due.size() == 0) begin
            log_mismatch("unrequested beat, channel", t_word'(out_mon.report_channel), '0);
            return;
        end
        want = reports_due.pop_front();
        if (out_mon.report_channel !== want.chn)
            log_mismatch("report_channel", t_word'(out_mon.report_channel), t_word'(want.chn));
        if (out_mon.report_source !== want.src)
            log_mismatch("report_source", out_mon.report_source, want.src);
        if (out_mon.report_dest !== want.dst)
            log_mismatch("report_dest", out_mon.report_dest, want.dst);
        if (out_mon.report_count !== want.cnt)
            log_mismatch("report_count", out_mon.report_count, want.cnt);
        if (out_mon.stuck !== want.stuck)
            log_mismatch("stuck", t_word'(out_mon.stuck), t_word'(want.stuck));
        if (out_mon.last !== want.last)
            log_mismatch("last", t_word'(out_mon.last), t_word'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                progress[i] = '0;
                checked[i]  = '0;
                held_src[i] = '0;
                held_dst[i] = '0;
            end
            reports_due.delete();
        end else begin
            if (in_mon.valid && in_mon.ready)
                track_command(in_mon.opcode, in_mon.channel, in_mon.msg_source,
                              in_mon.msg_dest);
            if (out_mon.valid && out_mon.ready)
                check_report();
        end
        o_errors  <= errors;
        o_pending <= reports_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the dispatch stall watchdog. The monitor beside
// the DUT does all prediction and comparison; this module only makes beats,
// paces both handshakes and decides pass/fail at the end.
module tb_top;
    import dsw_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   reports_owed;
    int   beats_sent;
    bit   send_burst;      // no gaps between command beats while set

    dsw_in_if  in_bus ();
    dsw_out_if out_bus ();

    dispatch_stall_watchdog DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    dsw_watchdog_monitor u_monitor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_bus),
        .out_mon   (out_bus),
        .o_errors  (mismatches),
        .o_pending (reports_owed)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop, sized well above the slowest legal run (every inspect's
    // eight reports each hit the longest sink stall, plus the long hold-off).
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // One command beat. Gap first (valid dropped only if there is a gap, so
    // back-to-back beats keep valid high), then hold until accepted.
    task automatic send_beat(input t_op op, input t_chn chn, input t_word src,
                             input t_word dst);
        int gap;
        if (beats_sent % 24 == 0)
            send_burst = ($urandom_range(0, 2) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.opcode     <= op;
        in_bus.channel    <= chn;
        in_bus.msg_source <= src;
        in_bus.msg_dest   <= dst;
        do @(posedge i_clk); while (!in_bus.ready);
        beats_sent++;
    endtask

    // Report sink: random stalls, calm stretches, and one long hold-off while
    // commands keep coming so the output backs up and input ready drops.
    initial begin
        int stall;
        int taken;
        bit calm;
        bit held_off;
        taken    = 0;
        calm     = 1'b0;
        held_off = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 20 == 0)
                calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, 14);
            if (taken == 40 && !held_off) begin
                stall    = 300;
                held_off = 1'b1;
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            taken++;
        end
    end

    initial begin
        t_chn  prev_ch;
        t_chn  chn;
        t_word dst;
        beats_sent        = 0;
        send_burst        = 1'b0;
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.opcode     <= OP_TRIGGER;
        in_bus.channel    <= '0;
        in_bus.msg_source <= '0;
        in_bus.msg_dest   <= '0;
        out_bus.ready     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // fresh store: every report all zero, nothing stuck
        send_beat(OP_INSPECT, 3'd0, '0, '0);
        // handle extremes on the end channels and on channel 3
        send_beat(OP_TRIGGER, 3'd0, '0, '1);
        send_beat(OP_TRIGGER, 3'd7, '1, '0);
        send_beat(OP_TRIGGER, 3'd3, '1, '1);
        // same channel back to back: count forwarding
        send_beat(OP_TRIGGER, 3'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_beat(OP_TRIGGER, 3'd5, '0, 32'h0000_0001);
        // counts moved: checked catches up, no flags; junk in ignored fields
        send_beat(OP_INSPECT, 3'd7, '1, '1);
        // nothing moved: 0, 3, 5 busy -> stuck; 7 idle -> not stuck
        send_beat(OP_INSPECT, 3'd0, '0, '0);
        // channel 0 goes idle with a fresh trigger
        send_beat(OP_TRIGGER, 3'd0, 32'h8000_0000, '0);
        send_beat(OP_INSPECT, 3'd2, 32'h0000_0001, 32'h8000_0000);
        // idle and unchanged: stays clear, no state change
        send_beat(OP_INSPECT, 3'd4, '0, '0);
        for (int c = 0; c < CHANNELS; c++)
            send_beat(OP_TRIGGER, t_chn'(c), $urandom, $urandom);
        send_beat(OP_INSPECT, 3'd1, $urandom, $urandom);

        // --- random ---
        // mostly triggers, rare inspects; some repeats on one channel, some
        // idle destinations, so stuck/idle/moving channels all show up
        prev_ch = '0;
        repeat (350) begin
            chn = ($urandom_range(0, 3) == 0) ? prev_ch : t_chn'($urandom_range(0, 7));
            case ($urandom_range(0, 7))
                0, 1:    dst = '0;
                2:       dst = '1;
                default: dst = $urandom;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                send_beat(OP_INSPECT, t_chn'($urandom), $urandom, $urandom);
            end else begin
                send_beat(OP_TRIGGER, chn, $urandom, dst);
                prev_ch = chn;
            end
        end
        in_bus.valid <= 1'b0;

        // let the monitor's count settle past the last accepted beat, drain,
        // then idle long enough to catch any stray report beat
        @(posedge i_clk);
        while (reports_owed != 0) @(posedge i_clk);
        repeat (2 * CHANNELS + 8) @(posedge i_clk);

        if (mismatches == 0 && reports_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
